/* src/chm_pkg.sv */
package chm_pkg;

  // Operation codes carried in the request
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_GET    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic        full_res;
  } resp_t;

endpackage

/* src/chm_ram.sv */
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/chm_hash.sv */
module chm_hash #(
  parameter int BUCKETS = 64,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   key,
  output logic          done,
  output logic [BW-1:0] bucket
);

  localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      logic [BW-1:0] bucket_r;

      // Take the low key bits into a register
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          bucket_r <= key[BW-1:0] & BW'(BUCKETS - 1);
        end
      end

      assign bucket = bucket_r;
    end else begin : g_recip
      // Rounded-up reciprocal, exact quotient for every 32-bit key
      localparam logic [32:0] RECIP =
        33'((((65'd1 << (32 + BW)) + 65'(BUCKETS)) - 65'd1) / 65'(BUCKETS));

      logic [2:0]    stage;
      logic [31:0]   key_r;
      logic [48:0]   prod_lo;
      logic [47:0]   prod_hi;
      logic [64:0]   prod;
      logic [31:0]   quot;
      logic [BW-1:0] rem;

      // Combine the two narrow partial products of key times reciprocal
      always_comb begin
        prod_hi = 48'(key_r) * 48'(RECIP[32:17]);
        prod    = {prod_hi, 17'd0} + {16'd0, prod_lo};
      end

      // Low partial product, quotient, then remainder, each registered in turn
      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          done  <= 1'b0;
        end else begin
          stage <= {stage[1:0], start};
          done  <= stage[2];
        end
        if (start) begin
          key_r <= key;
        end
        if (stage[0]) begin
          prod_lo <= 49'(key_r) * 49'(RECIP[16:0]);
        end
        if (stage[1]) begin
          quot <= 32'(prod >> (32 + BW));
        end
        if (stage[2]) begin
          rem <= key_r[BW-1:0] - BW'(quot[BW-1:0] * BW'(BUCKETS));
        end
      end

      assign bucket = rem;
    end
  endgenerate

endmodule

/* src/chained_hash_map_core.sv */
// A request passes hash, head load, one compare per chain node visited and decide;
// a fresh-node insert adds link, a free-list pop adds pop and link, a remove hit adds
// unlink and free push, and the unused code goes straight to the result. A BUCKETS
// not a power of two takes the key remainder through a reciprocal. One request at a
// time: the next is accepted the cycle after the result is registered, and a waiting
// result holds it off. Reset (synchronous) clears the bucket table, stalling requests.
module chained_hash_map_core #(
  parameter int BUCKETS = 64,
  parameter int POOL    = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  chm_pkg::req_t   req,
  output logic            resp_valid,
  input  logic            resp_stall,
  output chm_pkg::resp_t  resp
);

  localparam int PW = $clog2(POOL + 1);
  localparam int IW = $clog2(POOL);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(POOL);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_HASH      = 11'b000_0000_0100,
    S_LOAD_HEAD = 11'b000_0000_1000,
    S_CMP_NODE  = 11'b000_0001_0000,
    S_DECIDE    = 11'b000_0010_0000,
    S_FREE_POP  = 11'b000_0100_0000,
    S_LINK      = 11'b000_1000_0000,
    S_UNLINK    = 11'b001_0000_0000,
    S_FREE_PUSH = 11'b010_0000_0000,
    S_RESP      = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // Request and walk registers
  logic [1:0]    func_r;
  logic [31:0]   key_r;
  logic [31:0]   value_r;
  logic          hit_r;
  logic [31:0]   vout_r;
  logic          full_r;
  logic [PW-1:0] cur;
  logic [PW-1:0] prev;
  logic [PW-1:0] head;
  logic [PW-1:0] nxt;
  logic [PW-1:0] alloc;
  logic [PW-1:0] free_head;
  logic [PW-1:0] fresh_count;
  logic [BW-1:0] clr_idx;

  logic          accept;
  logic          hash_done;
  logic [BW-1:0] bucket;

  // Memory ports
  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [PW-1:0] head_wdata;
  logic [PW-1:0] head_rdata;
  logic          key_we;
  logic [31:0]   key_rdata;
  logic          val_we;
  logic [IW-1:0] val_waddr;
  logic [31:0]   val_rdata;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic [PW-1:0] link_rdata;
  logic [PW-1:0] link_clip;
  logic [IW-1:0] node_raddr;
  logic          key_match;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign link_clip = (link_rdata >= NIL) ? NIL : link_rdata;
  assign key_match = (key_rdata == key_r);

  chm_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && (req.func != chm_pkg::FUNC_NOP)),
    .key    (req.key),
    .done   (hash_done),
    .bucket (bucket)
  );

  chm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  chm_ram #(.WIDTH(32), .DEPTH(POOL)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (alloc[IW-1:0]),
    .wdata (key_r),
    .raddr (node_raddr),
    .rdata (key_rdata)
  );

  chm_ram #(.WIDTH(32), .DEPTH(POOL)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .raddr (node_raddr),
    .rdata (val_rdata)
  );

  chm_ram #(.WIDTH(PW), .DEPTH(POOL)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (node_raddr),
    .rdata (link_rdata)
  );

  // Sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = alloc;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = alloc[IW-1:0];
    link_we    = 1'b0;
    link_waddr = alloc[IW-1:0];
    link_wdata = head;
    node_raddr = cur[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_idx;
        head_wdata = NIL;
        if (clr_idx == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (req.func == chm_pkg::FUNC_NOP) ? S_RESP : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_LOAD_HEAD;
        end
      end
      S_LOAD_HEAD: begin
        node_raddr = head_rdata[IW-1:0];
        state_next = (head_rdata >= NIL) ? S_DECIDE : S_CMP_NODE;
      end
      S_CMP_NODE: begin
        node_raddr = link_rdata[IW-1:0];
        if (key_match || (link_rdata >= NIL)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        node_raddr = free_head[IW-1:0];
        state_next = S_RESP;
        case (func_r)
          chm_pkg::FUNC_INSERT: begin
            if (hit_r) begin
              val_we    = 1'b1;
              val_waddr = cur[IW-1:0];
            end else if (free_head < NIL) begin
              state_next = S_FREE_POP;
            end else if (fresh_count < NIL) begin
              state_next = S_LINK;
            end
          end
          chm_pkg::FUNC_REMOVE: begin
            if (hit_r) begin
              state_next = S_UNLINK;
            end
          end
          default: begin
          end
        endcase
      end
      S_FREE_POP: begin
        state_next = S_LINK;
      end
      S_LINK: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        state_next = S_RESP;
      end
      S_UNLINK: begin
        if (prev < NIL) begin
          link_we    = 1'b1;
          link_waddr = prev[IW-1:0];
          link_wdata = nxt;
        end else begin
          head_we    = 1'b1;
          head_wdata = nxt;
        end
        state_next = S_FREE_PUSH;
      end
      S_FREE_PUSH: begin
        link_we    = 1'b1;
        link_waddr = cur[IW-1:0];
        link_wdata = free_head;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!resp_valid || !resp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      free_head   <= NIL;
      fresh_count <= '0;
      resp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
      // Hand out a never-used node
      if ((state == S_DECIDE) && (func_r == chm_pkg::FUNC_INSERT) && !hit_r &&
          !(free_head < NIL) && (fresh_count < NIL)) begin
        fresh_count <= fresh_count + PW'(1);
      end
      // Pop and push the free list
      if (state == S_FREE_POP) begin
        free_head <= link_clip;
      end
      if (state == S_FREE_PUSH) begin
        free_head <= cur;
      end
      // Output register: load a result, drop it once taken
      if ((state == S_RESP) && (!resp_valid || !resp_stall)) begin
        resp_valid <= 1'b1;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= req.func;
      key_r   <= req.key;
      value_r <= req.value;
      hit_r   <= 1'b0;
      vout_r  <= '0;
      full_r  <= 1'b0;
    end
    if (state == S_LOAD_HEAD) begin
      cur  <= head_rdata;
      head <= head_rdata;
      prev <= NIL;
    end
    // Compare one node, advance along the chain on a mismatch
    if (state == S_CMP_NODE) begin
      if (key_match) begin
        hit_r  <= 1'b1;
        vout_r <= val_rdata;
        nxt    <= link_clip;
      end else begin
        prev <= cur;
        cur  <= link_rdata;
      end
    end
    if (state == S_DECIDE) begin
      alloc <= fresh_count;
      if ((func_r == chm_pkg::FUNC_INSERT) && !hit_r && !(free_head < NIL) &&
          !(fresh_count < NIL)) begin
        full_r <= 1'b1;
      end
    end
    if (state == S_FREE_POP) begin
      alloc <= free_head;
    end
    if ((state == S_RESP) && (!resp_valid || !resp_stall)) begin
      resp.hit       <= hit_r;
      resp.value_out <= vout_r;
      resp.full_res  <= full_r;
    end
  end

endmodule

/* src/chm_checker.sv */
module chm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           resp_valid,
  input logic           resp_stall,
  input chm_pkg::resp_t resp
);

  // Hold a stalled result
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid && $stable(resp))
    else $error("stalled result changed or dropped");

  // A miss or a refusal carries a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp.hit |-> resp.value_out == 32'd0)
    else $error("value without hit");

  // A refused insert never reports a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.full_res |-> !resp.hit)
    else $error("full and hit together");

  // Stall during the clearing pass after reset
  a_reset_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken right after reset");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .resp       (resp)
);

/* tb/sv/testbench.sv */
module testbench;

  localparam int BUCKETS = 64;
  localparam int POOL = 256;
  localparam logic [8:0] NIL = 9'(POOL);
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 40;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 60;
  localparam int BURST_ITEMS = 24;
  localparam int KEY_SET = 40;
  localparam int PRINT_CAP = 50;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  chm_pkg::req_t req;
  logic resp_valid;
  logic resp_stall = 1'b1;
  chm_pkg::resp_t resp;

  chained_hash_map_core #(
    .BUCKETS(BUCKETS),
    .POOL(POOL)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp(resp)
  );

  // Shadow copy of the map: bucket heads, node pool, free list
  logic [8:0] map_head [BUCKETS];
  logic [31:0] map_key [POOL];
  logic [31:0] map_val [POOL];
  logic [8:0] map_link [POOL];
  logic [8:0] map_free;
  logic [8:0] map_fresh;

  chm_pkg::resp_t pending_results[$];
  logic [31:0] key_set [KEY_SET];

  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int refusals_seen = 0;
  int cycle_count = 0;
  int rx_gap = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic hold_rx = 1'b0;
  event hold_rx_ev;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow map and return the result it produces
  function automatic chm_pkg::resp_t map_apply(input chm_pkg::req_t r);
    chm_pkg::resp_t o;
    int b, n, p, found, found_prev, steps, m, nxt;
    o = '0;
    if (r.func == chm_pkg::FUNC_NOP) return o;
    b = int'(r.key % BUCKETS);

    // walk the chain, bounded to the pool size
    n = map_head[b];
    p = POOL;
    found = POOL;
    found_prev = POOL;
    steps = 0;
    while (n < POOL && steps < POOL && found == POOL) begin
      if (map_key[n] == r.key) begin
        found = n;
        found_prev = p;
      end else begin
        p = n;
        n = map_link[n];
        steps++;
      end
    end
    if (found < POOL) begin
      o.hit = 1'b1;
      o.value_out = map_val[found];
    end

    case (r.func)
      chm_pkg::FUNC_INSERT: begin
        if (found < POOL) begin
          map_val[found] = r.value;
        end else begin
          // take a node from the free list first, then from the unused range
          m = POOL;
          if (map_free < NIL) begin
            m = map_free;
            map_free = (map_link[m] > NIL) ? NIL : map_link[m];
          end else if (map_fresh < POOL) begin
            m = map_fresh;
            map_fresh++;
          end
          if (m < POOL) begin
            map_key[m] = r.key;
            map_val[m] = r.value;
            map_link[m] = map_head[b];
            map_head[b] = 9'(m);
          end else begin
            o.full_res = 1'b1;
          end
        end
      end
      chm_pkg::FUNC_REMOVE: begin
        if (found < POOL) begin
          nxt = (map_link[found] > NIL) ? POOL : map_link[found];
          if (found_prev < POOL) map_link[found_prev] = 9'(nxt);
          else map_head[b] = 9'(nxt);
          map_link[found] = map_free;
          map_free = 9'(found);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (errors < PRINT_CAP)
      $display("result %0d: %s expected %h got %h", results_checked, what, want, got);
    errors++;
  endtask

  task automatic check_result(input chm_pkg::resp_t got);
    chm_pkg::resp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unrequested result, value_out", 32'h0, got.value_out);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.hit) hits_seen++;
    if (want.full_res) refusals_seen++;
    if (got.hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(got.hit));
    if (got.value_out !== want.value_out)
      report_mismatch("value_out", want.value_out, got.value_out);
    if (got.full_res !== want.full_res)
      report_mismatch("full_res", 32'(want.full_res), 32'(got.full_res));
  endtask

  // Send one request, first idling for a random gap if tx_idle_on is set
  task automatic send_request(input logic [1:0] f, input logic [31:0] k,
                              input logic [31:0] v);
    int gap;
    chm_pkg::req_t item;
    item.func = f;
    item.key = k;
    item.value = v;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(map_apply(item));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Accept results, then stall for a random gap if rx_idle_on is set, or while hold_rx is high
  always @(posedge clk) begin
    if (!rst && resp_valid && !resp_stall) begin
      check_result(resp);
      rx_gap = rx_idle_on ? $urandom_range(0, 16) : 0;
    end else if (rx_gap != 0) begin
      rx_gap--;
    end
    resp_stall <= hold_rx || (rx_gap != 0);
  end

  // Hold the receiver off for a long stretch on request
  initial begin
    forever begin
      @(hold_rx_ev);
      hold_rx <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      hold_rx <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("chained_hash_map_core: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_request(chm_pkg::FUNC_GET, 32'h0, 32'h1234_5678);
    send_request(chm_pkg::FUNC_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(chm_pkg::FUNC_GET, 32'h0, 32'h0);
    // overwrite in place
    send_request(chm_pkg::FUNC_INSERT, 32'h0, 32'h0);
    send_request(chm_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // build a three-node chain in bucket zero
    send_request(chm_pkg::FUNC_INSERT, 32'h40, 32'hA5A5_A5A5);
    send_request(chm_pkg::FUNC_INSERT, 32'h80, 32'h5A5A_5A5A);
    send_request(chm_pkg::FUNC_GET, 32'h40, 32'hFFFF_FFFF);
    send_request(chm_pkg::FUNC_GET, 32'h0, 32'h0);
    // unlink from the middle, then miss on get and remove
    send_request(chm_pkg::FUNC_REMOVE, 32'h40, 32'h0);
    send_request(chm_pkg::FUNC_GET, 32'h40, 32'h0);
    send_request(chm_pkg::FUNC_REMOVE, 32'h40, 32'h0);
    // unlink the head
    send_request(chm_pkg::FUNC_REMOVE, 32'h80, 32'h0);
    // reuse nodes from the free list
    send_request(chm_pkg::FUNC_INSERT, 32'hC0, 32'h0000_0001);
    send_request(chm_pkg::FUNC_INSERT, 32'h8000_003F, 32'h8000_0000);
    // unused selector leaves the map alone
    send_request(chm_pkg::FUNC_NOP, 32'h0, 32'hFFFF_FFFF);
    send_request(chm_pkg::FUNC_NOP, 32'hFFFF_FFFF, 32'h0);
    send_request(chm_pkg::FUNC_GET, 32'h0, 32'h0);
    send_request(chm_pkg::FUNC_REMOVE, 32'h0, 32'h0);
    send_request(chm_pkg::FUNC_REMOVE, 32'hC0, 32'h0);
    send_request(chm_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(chm_pkg::FUNC_GET, 32'h8000_003F, 32'h0);
    drain_results();
  endtask

  task automatic test_pool_exhaustion();
    int i;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // fill the pool past its size; the last inserts are refused
    for (i = 0; i < POOL + 4; i++)
      send_request(chm_pkg::FUNC_INSERT, {8'hC3, 24'(i)}, $urandom());
    // overwrite while full, look up a refused key
    send_request(chm_pkg::FUNC_INSERT, {8'hC3, 24'd5}, $urandom());
    send_request(chm_pkg::FUNC_GET, {8'hC3, 24'(POOL)}, 32'h0);
    // free a slice of the pool in two interleaved passes to scramble the free list
    for (i = 0; i < POOL + 4; i += 16)
      send_request(chm_pkg::FUNC_REMOVE, {8'hC3, 24'(i)}, 32'h0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (i = 8; i < POOL + 4; i += 16)
      send_request(chm_pkg::FUNC_REMOVE, {8'hC3, 24'(i)}, 32'h0);
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    int i, sel;
    logic [1:0] f;
    logic [31:0] k, v;
    for (i = 0; i < count; i++) begin
      // leave a stretch with no idling on either side
      tx_idle_on = !(i >= count / 2 && i < count / 2 + count / 4);
      rx_idle_on = !(i >= count / 2 + count / 8 && i < count / 2 + (3 * count) / 8);
      sel = $urandom_range(0, 99);
      if (sel < 45) f = chm_pkg::FUNC_INSERT;
      else if (sel < 70) f = chm_pkg::FUNC_GET;
      else if (sel < 95) f = chm_pkg::FUNC_REMOVE;
      else f = chm_pkg::FUNC_NOP;
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = key_set[$urandom_range(0, KEY_SET - 1)];
      case ($urandom_range(0, 15))
        0: v = 32'h0;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
      send_request(f, k, v);
    end
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    logic [1:0] f;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    -> hold_rx_ev;
    // keep offering requests while results are held back
    for (i = 0; i < BURST_ITEMS; i++) begin
      case (i % 3)
        0: f = chm_pkg::FUNC_INSERT;
        1: f = chm_pkg::FUNC_GET;
        default: f = chm_pkg::FUNC_REMOVE;
      endcase
      send_request(f, key_set[$urandom_range(0, 7)], $urandom());
    end
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    int i;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;

    // reset the shadow map
    for (i = 0; i < BUCKETS; i++) map_head[i] = NIL;
    for (i = 0; i < POOL; i++) begin
      map_key[i] = '0;
      map_val[i] = '0;
      map_link[i] = '0;
    end
    map_free = NIL;
    map_fresh = '0;

    // keys crowded into a few buckets for long chains
    for (i = 0; i < KEY_SET; i++) begin
      key_set[i] = $urandom();
      key_set[i][5:0] = 6'($urandom_range(0, 5));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_pool_exhaustion();
    test_random_traffic(RANDOM_ITEMS);
    test_backpressure();

    $display("ran %0d requests: %0d hits, %0d refused inserts, %0d results checked",
             requests_sent, hits_seen, refusals_seen, results_checked);
    $display("covered chain walks, free-list reuse, pool exhaustion and a long output stall");
    if (errors == 0) begin
      $display("chained_hash_map_core: match");
    end else begin
      $display("chained_hash_map_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/chm_pkg.sv
src/chm_ram.sv
src/chm_hash.sv
src/chained_hash_map_core.sv
src/chm_checker.sv
tb/sv/testbench.sv
